@@ hdl/rgbe_rle_pkg.sv @@
// Package for the RGBE scanline run-length decoder.
// Holds the decode phase type, result and error codes and size constants.
// No dependencies.
package rgbe_rle_pkg;

  localparam int unsigned MAX_LINE_WIDTH_DEF = 32767;
  localparam int unsigned MIN_NEW_WIDTH      = 8;
  localparam int unsigned LINE_WIDTH_RESET   = 8;

  localparam logic [7:0] NEW_MARK_BYTE = 8'd2;
  localparam logic [7:0] RUN_CODE_BASE = 8'd128;

  typedef enum logic [7:0] {
    PH_START  = 8'b0000_0001,
    PH_OLD    = 8'b0000_0010,
    PH_HDR_G  = 8'b0000_0100,
    PH_HDR_B  = 8'b0000_1000,
    PH_HDR_W  = 8'b0001_0000,
    PH_CODE   = 8'b0010_0000,
    PH_RUNVAL = 8'b0100_0000,
    PH_LIT    = 8'b1000_0000
  } phase_t;

  typedef enum logic [1:0] {
    KIND_CHANNEL = 2'd0,
    KIND_PIXEL   = 2'd1,
    KIND_ERROR   = 2'd2
  } write_kind_t;

  typedef enum logic [1:0] {
    ERR_NONE      = 2'd0,
    ERR_TRUNCATED = 2'd1,
    ERR_WIDTH     = 2'd2,
    ERR_OVERRUN   = 2'd3
  } error_code_t;

  typedef enum logic [1:0] {
    SHIFT_0  = 2'd0,
    SHIFT_8  = 2'd1,
    SHIFT_16 = 2'd2
  } rep_shift_t;

  localparam logic [1:0] CHAN_EXP = 2'd3;

endpackage

@@ hdl/rgbe_scanline_rle_decoder.sv @@
// Top level of the RGBE scanline run-length decoder.
// Decodes old-format and new-format scanline bytes into fill requests.
// Depends on rgbe_rle_pkg.

// One byte request is decoded per clock cycle: the whole decode of a byte is
// combinational logic from the input port and the decode state into the
// result register, so a new byte is taken in every cycle as long as the
// result register is empty or its request is being taken in the same cycle.
// Each byte yields at most one fill request (a run of one channel, a run of
// whole pixels, or an error) in the cycle after it is taken. line_width is
// written through cfg_wr_en/cfg_wr_data and resets to 8.
module rgbe_scanline_rle_decoder #(
  parameter int unsigned MAX_LINE_WIDTH = rgbe_rle_pkg::MAX_LINE_WIDTH_DEF
) (
  input  logic        clk,
  input  logic        rst_n,

  input  logic        cfg_wr_en,
  input  logic [14:0] cfg_wr_data,

  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  in_data_byte,
  input  logic        in_end_of_stream,

  output logic        out_valid,
  input  logic        out_ready,
  output logic [1:0]  out_write_kind,
  output logic [1:0]  out_channel,
  output logic [14:0] out_first_pixel,
  output logic [14:0] out_pixel_count,
  output logic [31:0] out_pixel_value,
  output logic        out_line_done,
  output logic [1:0]  out_error_code
);

  rgbe_rle_pkg::phase_t     phase_r, phase_nxt;
  rgbe_rle_pkg::rep_shift_t shift_r, shift_nxt;
  logic [14:0] line_width_r;
  logic [15:0] pos_r, pos_nxt;
  logic [1:0]  chan_r, chan_nxt;
  logic [1:0]  nbytes_r, nbytes_nxt;
  logic [23:0] acc_r, acc_nxt;
  logic [31:0] prev_pix_r, prev_pix_nxt;
  logic [7:0]  left_r, left_nxt;
  logic [7:0]  hdr_g_r, hdr_g_nxt;
  logic [7:0]  hdr_b_r, hdr_b_nxt;

  logic        out_valid_r;
  logic [1:0]  kind_r, kind_nxt;
  logic [1:0]  ochan_r, ochan_nxt;
  logic [14:0] first_r, first_nxt;
  logic [14:0] count_r, count_nxt;
  logic [31:0] value_r, value_nxt;
  logic        done_r, done_nxt;
  logic [1:0]  err_r, err_nxt;
  logic        emit;

  logic        accept;
  logic [15:0] lw16;

  assign in_ready = !out_valid_r || out_ready;
  assign accept   = in_valid && in_ready;
  assign lw16     = {1'b0, line_width_r};

  always_comb begin
    logic        st;
    logic [15:0] pos_b;
    logic [1:0]  nb_b;
    logic [23:0] acc_b;
    logic [31:0] prev_b;
    rgbe_rle_pkg::rep_shift_t shift_b;
    logic [15:0] rest;
    logic        old_go;
    logic        px_go;
    logic [31:0] pix;
    logic [16:0] cnt_raw;
    logic [15:0] cnt;
    logic [16:0] pos_sum;
    logic [15:0] pos_p1;
    logic        pdone;
    logic [7:0]  b;
    logic [7:0]  n;
    logic        adv_go;
    logic [15:0] adv_pos;
    logic [7:0]  adv_left;
    logic [15:0] adv_start;
    logic [15:0] adv_cnt;

    b = in_data_byte;
    st = (phase_r == rgbe_rle_pkg::PH_START);
    pos_b   = st ? 16'd0 : pos_r;
    nb_b    = st ? 2'd0 : nbytes_r;
    acc_b   = st ? 24'd0 : acc_r;
    prev_b  = st ? 32'd0 : prev_pix_r;
    shift_b = st ? rgbe_rle_pkg::SHIFT_0 : shift_r;
    rest    = (pos_b < lw16) ? (lw16 - pos_b) : 16'd0;
    n       = (b > rgbe_rle_pkg::RUN_CODE_BASE) ? {1'b0, b[6:0]} : b;

    phase_nxt    = phase_r;
    shift_nxt    = shift_b;
    pos_nxt      = pos_b;
    chan_nxt     = st ? 2'd0 : chan_r;
    nbytes_nxt   = nb_b;
    acc_nxt      = acc_b;
    prev_pix_nxt = prev_b;
    left_nxt     = st ? 8'd0 : left_r;
    hdr_g_nxt    = hdr_g_r;
    hdr_b_nxt    = hdr_b_r;

    emit      = 1'b0;
    kind_nxt  = rgbe_rle_pkg::KIND_PIXEL;
    ochan_nxt = 2'd0;
    first_nxt = 15'd0;
    count_nxt = 15'd0;
    value_nxt = 32'd0;
    done_nxt  = 1'b0;
    err_nxt   = rgbe_rle_pkg::ERR_NONE;

    old_go    = 1'b0;
    px_go     = 1'b0;
    pix       = {acc_b, b};
    adv_go    = 1'b0;
    adv_pos   = pos_r;
    adv_left  = left_r;
    adv_start = pos_r;
    adv_cnt   = 16'd0;
    cnt_raw   = 17'd0;
    cnt       = 16'd0;
    pos_sum   = 17'd0;
    pos_p1    = 16'd0;
    pdone     = 1'b0;

    if (in_end_of_stream) begin
      emit      = 1'b1;
      kind_nxt  = rgbe_rle_pkg::KIND_ERROR;
      err_nxt   = rgbe_rle_pkg::ERR_TRUNCATED;
      phase_nxt = rgbe_rle_pkg::PH_START;
      pos_nxt      = pos_r;
      chan_nxt     = chan_r;
      nbytes_nxt   = nbytes_r;
      acc_nxt      = acc_r;
      prev_pix_nxt = prev_pix_r;
      shift_nxt    = shift_r;
      left_nxt     = left_r;
    end else begin
      unique case (phase_r)
        rgbe_rle_pkg::PH_START: begin
          if (line_width_r == 15'd0) begin
            emit     = 1'b1;
            done_nxt = 1'b1;
          end else if (line_width_r >= 15'(rgbe_rle_pkg::MIN_NEW_WIDTH) &&
                       {17'd0, line_width_r} <= 32'(MAX_LINE_WIDTH) &&
                       b == rgbe_rle_pkg::NEW_MARK_BYTE) begin
            phase_nxt = rgbe_rle_pkg::PH_HDR_G;
          end else begin
            phase_nxt = rgbe_rle_pkg::PH_OLD;
            old_go    = 1'b1;
          end
        end
        rgbe_rle_pkg::PH_OLD: begin
          old_go = 1'b1;
        end
        rgbe_rle_pkg::PH_HDR_G: begin
          hdr_g_nxt = b;
          phase_nxt = rgbe_rle_pkg::PH_HDR_B;
        end
        rgbe_rle_pkg::PH_HDR_B: begin
          hdr_b_nxt = b;
          phase_nxt = rgbe_rle_pkg::PH_HDR_W;
        end
        rgbe_rle_pkg::PH_HDR_W: begin
          if (hdr_g_r != rgbe_rle_pkg::NEW_MARK_BYTE || hdr_b_r[7]) begin
            phase_nxt = rgbe_rle_pkg::PH_OLD;
            shift_b   = rgbe_rle_pkg::SHIFT_0;
            px_go     = 1'b1;
            pix       = {rgbe_rle_pkg::NEW_MARK_BYTE, hdr_g_r, hdr_b_r, b};
          end else if ({hdr_b_r, b} != lw16) begin
            emit      = 1'b1;
            kind_nxt  = rgbe_rle_pkg::KIND_ERROR;
            err_nxt   = rgbe_rle_pkg::ERR_WIDTH;
            phase_nxt = rgbe_rle_pkg::PH_START;
          end else begin
            pos_nxt   = 16'd0;
            chan_nxt  = 2'd0;
            left_nxt  = 8'd0;
            phase_nxt = rgbe_rle_pkg::PH_CODE;
          end
        end
        rgbe_rle_pkg::PH_CODE: begin
          if (n != 8'd0) begin
            if ({8'd0, n} > rest) begin
              emit      = 1'b1;
              kind_nxt  = rgbe_rle_pkg::KIND_ERROR;
              err_nxt   = rgbe_rle_pkg::ERR_OVERRUN;
              phase_nxt = rgbe_rle_pkg::PH_START;
            end else begin
              left_nxt  = n;
              phase_nxt = (b > rgbe_rle_pkg::RUN_CODE_BASE) ? rgbe_rle_pkg::PH_RUNVAL
                                                           : rgbe_rle_pkg::PH_LIT;
            end
          end
        end
        rgbe_rle_pkg::PH_RUNVAL: begin
          adv_go   = 1'b1;
          adv_pos  = pos_r + {8'd0, left_r};
          adv_left = 8'd0;
          adv_cnt  = {8'd0, left_r};
        end
        rgbe_rle_pkg::PH_LIT: begin
          adv_go   = 1'b1;
          adv_pos  = pos_r + 16'd1;
          adv_left = (left_r != 8'd0) ? (left_r - 8'd1) : 8'd0;
          adv_cnt  = 16'd1;
        end
        default: begin
          phase_nxt = rgbe_rle_pkg::PH_START;
        end
      endcase
    end

    // gather old-format bytes into pixels
    if (old_go) begin
      acc_nxt    = {acc_b[15:0], b};
      nbytes_nxt = nb_b + 2'd1;
      if (nb_b == 2'd3) begin
        px_go = 1'b1;
        pix   = {acc_b, b};
      end
    end

    if (px_go) begin
      if (pix[31:8] == 24'h01_01_01) begin
        if (pix[7:0] == 8'd0) begin
          cnt_raw = 17'd0;
        end else begin
          unique case (shift_b)
            rgbe_rle_pkg::SHIFT_0:  cnt_raw = {9'd0, pix[7:0]};
            rgbe_rle_pkg::SHIFT_8:  cnt_raw = {1'b0, pix[7:0], 8'd0};
            rgbe_rle_pkg::SHIFT_16: cnt_raw = {1'b0, rest};
            default:                cnt_raw = {1'b0, rest};
          endcase
        end
        cnt       = (cnt_raw > {1'b0, rest}) ? rest : cnt_raw[15:0];
        shift_nxt = (shift_b == rgbe_rle_pkg::SHIFT_0) ? rgbe_rle_pkg::SHIFT_8
                                                       : rgbe_rle_pkg::SHIFT_16;
        pos_sum   = {1'b0, pos_b} + {1'b0, cnt};
        pos_nxt   = pos_sum[15:0];
        pdone     = (pos_sum >= {1'b0, lw16});
        if (pdone) begin
          phase_nxt = rgbe_rle_pkg::PH_START;
        end
        if (cnt != 16'd0 || pdone) begin
          emit      = 1'b1;
          first_nxt = pos_b[14:0];
          count_nxt = cnt[14:0];
          value_nxt = prev_b;
          done_nxt  = pdone;
        end
      end else begin
        shift_nxt    = rgbe_rle_pkg::SHIFT_0;
        prev_pix_nxt = pix;
        pos_p1       = pos_b + 16'd1;
        pos_nxt      = pos_p1;
        pdone        = (pos_p1 >= lw16);
        if (pdone) begin
          phase_nxt = rgbe_rle_pkg::PH_START;
        end
        emit      = 1'b1;
        first_nxt = pos_b[14:0];
        count_nxt = 15'd1;
        value_nxt = pix;
        done_nxt  = pdone;
      end
    end

    // finish a channel run or literal, then step channel or line
    if (adv_go) begin
      emit      = 1'b1;
      kind_nxt  = rgbe_rle_pkg::KIND_CHANNEL;
      ochan_nxt = chan_r;
      first_nxt = adv_start[14:0];
      count_nxt = adv_cnt[14:0];
      value_nxt = {24'd0, b};
      left_nxt  = adv_left;
      pos_nxt   = adv_pos;
      phase_nxt = (adv_left != 8'd0) ? rgbe_rle_pkg::PH_LIT : rgbe_rle_pkg::PH_CODE;
      if (adv_pos >= lw16) begin
        pos_nxt  = 16'd0;
        chan_nxt = chan_r + 2'd1;
        if (chan_r == rgbe_rle_pkg::CHAN_EXP) begin
          phase_nxt = rgbe_rle_pkg::PH_START;
          done_nxt  = 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r      <= rgbe_rle_pkg::PH_START;
      line_width_r <= 15'(rgbe_rle_pkg::LINE_WIDTH_RESET);
      out_valid_r  <= 1'b0;
    end else begin
      if (cfg_wr_en) begin
        line_width_r <= cfg_wr_data;
      end
      if (accept) begin
        phase_r <= phase_nxt;
      end
      if (in_ready) begin
        out_valid_r <= accept && emit;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      pos_r      <= pos_nxt;
      chan_r     <= chan_nxt;
      nbytes_r   <= nbytes_nxt;
      acc_r      <= acc_nxt;
      prev_pix_r <= prev_pix_nxt;
      shift_r    <= shift_nxt;
      left_r     <= left_nxt;
      hdr_g_r    <= hdr_g_nxt;
      hdr_b_r    <= hdr_b_nxt;
    end
    if (accept && emit) begin
      kind_r  <= kind_nxt;
      ochan_r <= ochan_nxt;
      first_r <= first_nxt;
      count_r <= count_nxt;
      value_r <= value_nxt;
      done_r  <= done_nxt;
      err_r   <= err_nxt;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_write_kind  = kind_r;
  assign out_channel     = ochan_r;
  assign out_first_pixel = first_r;
  assign out_pixel_count = count_r;
  assign out_pixel_value = value_r;
  assign out_line_done   = done_r;
  assign out_error_code  = err_r;

endmodule

@@ test/tb_top.sv @@
`timescale 1ns / 1ps
// Testbench for rgbe_scanline_rle_decoder: byte requests in, fill requests out.
// A directed table, then random old-format, new-format and broken scanlines,
// all checked against a behavioral decoder. Depends on rgbe_rle_pkg.
module tb_top;
  import rgbe_rle_pkg::*;

  localparam int unsigned STALL_LIMIT = 5000;
  localparam int unsigned BYTE_TARGET = 1550;

  typedef struct packed {
    write_kind_t write_kind;
    logic [1:0]  channel;
    logic [14:0] first_pixel;
    logic [14:0] pixel_count;
    logic [31:0] pixel_value;
    logic        line_done;
    error_code_t error_code;
  } fill_t;

  typedef struct {
    logic [7:0]  data_byte;
    bit          eos;
    bit          typed;
    fill_t       fill;
    bit          set_width;
    logic [14:0] width;
  } step_t;

  logic        clk = 1'b0;
  logic        rst_n;
  logic        cfg_wr_en;
  logic [14:0] cfg_wr_data;
  logic        in_valid;
  logic        in_ready;
  logic [7:0]  in_data_byte;
  logic        in_end_of_stream;
  logic        out_valid;
  logic        out_ready;
  logic [1:0]  out_write_kind;
  logic [1:0]  out_channel;
  logic [14:0] out_first_pixel;
  logic [14:0] out_pixel_count;
  logic [31:0] out_pixel_value;
  logic        out_line_done;
  logic [1:0]  out_error_code;

  fill_t       pending_fills[$];
  step_t       directed_steps[$];
  int unsigned mismatches = 0;
  int unsigned bytes_sent = 0;
  int unsigned stall_cycles = 0;
  int unsigned send_idle_pct;
  int unsigned recv_idle_pct;

  logic [14:0] dec_width;
  phase_t      dec_phase;
  int unsigned dec_pos;
  int unsigned dec_chan;
  int unsigned dec_nbytes;
  int unsigned dec_shift;
  int unsigned dec_left;
  logic [31:0] dec_acc;
  logic [31:0] dec_prev;
  logic [7:0]  dec_hdr_g;
  logic [7:0]  dec_hdr_b;

  rgbe_scanline_rle_decoder dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .cfg_wr_en        (cfg_wr_en),
    .cfg_wr_data      (cfg_wr_data),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_data_byte     (in_data_byte),
    .in_end_of_stream (in_end_of_stream),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_write_kind   (out_write_kind),
    .out_channel      (out_channel),
    .out_first_pixel  (out_first_pixel),
    .out_pixel_count  (out_pixel_count),
    .out_pixel_value  (out_pixel_value),
    .out_line_done    (out_line_done),
    .out_error_code   (out_error_code)
  );

  always #4 clk = ~clk;

  function automatic fill_t make_fill(write_kind_t kind, int unsigned chan, int unsigned first,
                                      int unsigned cnt, logic [31:0] value, bit done,
                                      error_code_t err);
    fill_t f;
    f.write_kind  = kind;
    f.channel     = chan[1:0];
    f.first_pixel = first[14:0];
    f.pixel_count = cnt[14:0];
    f.pixel_value = value;
    f.line_done   = done;
    f.error_code  = err;
    return f;
  endfunction

  function automatic int unsigned rest_of_line();
    return (dec_pos < dec_width) ? dec_width - dec_pos : 0;
  endfunction

  function automatic bit old_pixel_fill(input logic [31:0] pix, output fill_t f);
    int unsigned start;
    int unsigned rest;
    int unsigned cnt;
    bit done;
    start = dec_pos;
    if (pix[31:8] == 24'h010101) begin
      rest = rest_of_line();
      if (pix[7:0] == 8'd0) cnt = 0;
      else if (dec_shift >= 16) cnt = rest;
      else cnt = 32'(pix[7:0]) << dec_shift;
      if (cnt > rest) cnt = rest;
      if (dec_shift < 16) dec_shift += 8;
      dec_pos += cnt;
      done = dec_pos >= dec_width;
      if (done) dec_phase = PH_START;
      if (cnt == 0 && !done) return 0;
      f = make_fill(KIND_PIXEL, 0, start, cnt, dec_prev, done, ERR_NONE);
      return 1;
    end
    dec_shift = 0;
    dec_prev = pix;
    dec_pos++;
    done = dec_pos >= dec_width;
    if (done) dec_phase = PH_START;
    f = make_fill(KIND_PIXEL, 0, start, 1, pix, done, ERR_NONE);
    return 1;
  endfunction

  function automatic bit old_byte_fill(input logic [7:0] b, output fill_t f);
    dec_acc = {dec_acc[23:0], b};
    dec_nbytes++;
    if (dec_nbytes < 4) return 0;
    dec_nbytes = 0;
    return old_pixel_fill(dec_acc, f);
  endfunction

  function automatic bit advance_channel();
    if (dec_pos >= dec_width) begin
      dec_pos = 0;
      dec_chan++;
      if (dec_chan >= 4) begin
        dec_phase = PH_START;
        return 1;
      end
    end
    dec_phase = (dec_left > 0) ? PH_LIT : PH_CODE;
    return 0;
  endfunction

  function automatic bit predict_fill(input logic [7:0] b, input bit eos, output fill_t f);
    int unsigned n;
    int unsigned start;
    int unsigned chan;
    bit done;
    if (eos) begin
      f = make_fill(KIND_ERROR, 0, 0, 0, 0, 0, ERR_TRUNCATED);
      dec_phase = PH_START;
      return 1;
    end
    case (dec_phase)
      PH_START: begin
        dec_pos = 0; dec_chan = 0; dec_nbytes = 0; dec_acc = 0;
        dec_prev = 0; dec_shift = 0; dec_left = 0;
        if (dec_width == 0) begin
          f = make_fill(KIND_PIXEL, 0, 0, 0, 0, 1, ERR_NONE);
          return 1;
        end
        if (dec_width >= MIN_NEW_WIDTH && b == NEW_MARK_BYTE) begin
          dec_phase = PH_HDR_G;
          return 0;
        end
        dec_phase = PH_OLD;
        return old_byte_fill(b, f);
      end
      PH_OLD: return old_byte_fill(b, f);
      PH_HDR_G: begin
        dec_hdr_g = b;
        dec_phase = PH_HDR_B;
        return 0;
      end
      PH_HDR_B: begin
        dec_hdr_b = b;
        dec_phase = PH_HDR_W;
        return 0;
      end
      PH_HDR_W: begin
        if (dec_hdr_g != NEW_MARK_BYTE || dec_hdr_b[7]) begin
          dec_phase = PH_OLD;
          dec_shift = 0;
          return old_pixel_fill({NEW_MARK_BYTE, dec_hdr_g, dec_hdr_b, b}, f);
        end
        if ({dec_hdr_b[6:0], b} != dec_width) begin
          f = make_fill(KIND_ERROR, 0, 0, 0, 0, 0, ERR_WIDTH);
          dec_phase = PH_START;
          return 1;
        end
        dec_pos = 0; dec_chan = 0; dec_left = 0;
        dec_phase = PH_CODE;
        return 0;
      end
      PH_CODE: begin
        n = (b > RUN_CODE_BASE) ? 32'(b[6:0]) : 32'(b);
        if (n == 0) return 0;
        if (n > rest_of_line()) begin
          f = make_fill(KIND_ERROR, 0, 0, 0, 0, 0, ERR_OVERRUN);
          dec_phase = PH_START;
          return 1;
        end
        dec_left = n;
        dec_phase = (b > RUN_CODE_BASE) ? PH_RUNVAL : PH_LIT;
        return 0;
      end
      PH_RUNVAL: begin
        start = dec_pos;
        n = dec_left;
        chan = dec_chan;
        dec_pos += n;
        dec_left = 0;
        done = advance_channel();
        f = make_fill(KIND_CHANNEL, chan, start, n, {24'd0, b}, done, ERR_NONE);
        return 1;
      end
      default: begin
        start = dec_pos;
        chan = dec_chan;
        dec_pos++;
        if (dec_left > 0) dec_left--;
        done = advance_channel();
        f = make_fill(KIND_CHANNEL, chan, start, 1, {24'd0, b}, done, ERR_NONE);
        return 1;
      end
    endcase
  endfunction

  task automatic send_byte(input logic [7:0] b, input bit eos, input bit typed = 0,
                           input fill_t typed_fill = '0);
    fill_t f;
    bit has_fill;
    @(negedge clk);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    in_data_byte <= b;
    in_end_of_stream <= eos;
    do @(posedge clk); while (!in_ready);
    has_fill = predict_fill(b, eos, f);
    if (typed) pending_fills.push_back(typed_fill);
    else if (has_fill) pending_fills.push_back(f);
    bytes_sent++;
  endtask

  task automatic settle();
    @(negedge clk);
    in_valid <= 1'b0;
    while (pending_fills.size() != 0) @(negedge clk);
    repeat (3) @(negedge clk);
  endtask

  task automatic set_line_width(input logic [14:0] w);
    settle();
    cfg_wr_en <= 1'b1;
    cfg_wr_data <= w;
    @(posedge clk);
    dec_width = w;
    @(negedge clk);
    cfg_wr_en <= 1'b0;
  endtask

  task automatic resync();
    if (dec_phase != PH_START) send_byte(8'($urandom), 1);
  endtask

  task automatic send_noise(input int unsigned n);
    repeat (n) send_byte(8'($urandom), $urandom_range(19) == 0);
  endtask

  task automatic send_old_line(input int unsigned max_pix);
    int unsigned n;
    int unsigned markers;
    int unsigned pick;
    logic [31:0] pix;
    n = 0;
    markers = 0;
    do begin
      if (markers == 0 && $urandom_range(99) < 25) markers = $urandom_range(3, 1);
      if (markers > 0) begin
        markers--;
        pick = $urandom_range(9);
        pix = {24'h010101, (pick < 3) ? 8'd0 : (pick < 6) ? 8'($urandom_range(3, 1))
                                                           : 8'($urandom)};
      end else begin
        pix = $urandom;
      end
      if (n == 0 && pix[31:24] == NEW_MARK_BYTE && $urandom_range(3) != 0) pix[31:24] = 8'h03;
      for (int i = 3; i >= 0; i--) send_byte(pix[i*8 +: 8], 0);
      n++;
    end while (dec_phase != PH_START && n < max_pix);
  endtask

  task automatic send_new_line(input bit spoil);
    int unsigned w;
    int unsigned rest;
    int unsigned n;
    int unsigned lim;
    int unsigned codes_left;
    w = dec_width;
    codes_left = spoil ? $urandom_range(20, 1) : 32'hFFFF_FFFF;
    send_byte(NEW_MARK_BYTE, 0);
    send_byte(NEW_MARK_BYTE, 0);
    send_byte({1'b0, w[14:8]}, 0);
    send_byte(w[7:0], 0);
    for (int ch = 0; ch < 4; ch++) begin
      rest = w;
      while (rest > 0) begin
        if (codes_left == 0) begin
          case ($urandom_range(2))
            0: send_byte(8'($urandom), 1);
            1: begin
              if (rest < 127) begin
                n = $urandom_range(127, rest + 1);
                send_byte($urandom_range(1) ? (8'h80 | 8'(n)) : 8'(n), 0);
              end else begin
                send_byte(8'($urandom), 1);
              end
            end
            default: ;
          endcase
          return;
        end
        codes_left--;
        if ($urandom_range(9) == 0) begin
          send_byte(8'h00, 0);
        end else begin
          lim = (rest < 127) ? rest : 127;
          if ($urandom_range(99) < ((w > 64) ? 90 : 50)) begin
            n = $urandom_range(lim, 1);
            send_byte(8'h80 | 8'(n), 0);
            send_byte(8'($urandom), 0);
          end else begin
            if (w > 64 && lim > 8) lim = 8;
            n = $urandom_range(lim, 1);
            send_byte(8'(n), 0);
            repeat (n) send_byte(8'($urandom), 0);
          end
          rest -= n;
        end
      end
    end
  endtask

  task automatic send_bad_header();
    logic [14:0] other;
    logic [7:0]  g;
    case ($urandom_range(2))
      0: begin
        other = dec_width ^ 15'($urandom_range(32767, 1));
        send_byte(NEW_MARK_BYTE, 0);
        send_byte(NEW_MARK_BYTE, 0);
        send_byte({1'b0, other[14:8]}, 0);
        send_byte(other[7:0], 0);
      end
      1: begin
        g = 8'($urandom);
        if (g == NEW_MARK_BYTE) g = 8'h03;
        send_byte(NEW_MARK_BYTE, 0);
        send_byte(g, 0);
        send_byte(8'($urandom), 0);
        send_byte(8'($urandom), 0);
      end
      default: begin
        send_byte(NEW_MARK_BYTE, 0);
        send_byte(NEW_MARK_BYTE, 0);
        send_byte(8'h80 | 8'($urandom), 0);
        send_byte(8'($urandom), 0);
      end
    endcase
  endtask

  function automatic void add_row(logic [7:0] b, bit eos = 0, bit typed = 0, fill_t f = '0,
                                  bit set_w = 0, logic [14:0] w = '0);
    step_t s;
    s.data_byte = b;
    s.eos = eos;
    s.typed = typed;
    s.fill = f;
    s.set_width = set_w;
    s.width = w;
    directed_steps.push_back(s);
  endfunction

  task automatic check_field(input string name, input logic [31:0] want,
                             input logic [31:0] got);
    if (got !== want) begin
      $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
      mismatches++;
    end
  endtask

  always @(negedge clk) begin
    out_ready <= ($urandom_range(99) >= recv_idle_pct);
  end

  always @(posedge clk) begin
    fill_t want;
    if (rst_n && out_valid && out_ready) begin
      if (pending_fills.size() == 0) begin
        $display("%0t: fill request with none expected, kind %0d first %0d count %0d err %0d",
                 $time, out_write_kind, out_first_pixel, out_pixel_count, out_error_code);
        mismatches++;
      end else begin
        want = pending_fills.pop_front();
        check_field("write_kind", want.write_kind, out_write_kind);
        check_field("channel", want.channel, out_channel);
        check_field("first_pixel", want.first_pixel, out_first_pixel);
        check_field("pixel_count", want.pixel_count, out_pixel_count);
        check_field("pixel_value", want.pixel_value, out_pixel_value);
        check_field("line_done", want.line_done, out_line_done);
        check_field("error_code", want.error_code, out_error_code);
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready)) stall_cycles <= 0;
    else stall_cycles <= stall_cycles + 1;
  end

  initial begin
    wait (stall_cycles >= STALL_LIMIT);
    $display("%0t: no request moved for %0d cycles", $time, STALL_LIMIT);
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

  initial begin
    int unsigned phase_idx;
    int unsigned lines;
    int unsigned pick;
    logic [14:0] w;
    rst_n = 1'b0;
    cfg_wr_en = 1'b0;
    cfg_wr_data = '0;
    in_valid = 1'b0;
    in_data_byte = '0;
    in_end_of_stream = 1'b0;
    out_ready = 1'b0;
    send_idle_pct = 18;
    recv_idle_pct = 76;
    dec_width = 15'(LINE_WIDTH_RESET);
    dec_phase = PH_START;
    dec_pos = 0; dec_chan = 0; dec_nbytes = 0; dec_shift = 0; dec_left = 0;
    dec_acc = 0; dec_prev = 0; dec_hdr_g = 0; dec_hdr_b = 0;
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    add_row(8'h00, 1, 1, make_fill(KIND_ERROR, 0, 0, 0, 0, 0, ERR_TRUNCATED));
    add_row(8'hFF); add_row(8'hFF); add_row(8'hFF);
    add_row(8'hFF, 0, 1, make_fill(KIND_PIXEL, 0, 0, 1, 32'hFFFF_FFFF, 0, ERR_NONE));
    add_row(8'h01); add_row(8'h01); add_row(8'h01);
    add_row(8'hFF, 0, 1, make_fill(KIND_PIXEL, 0, 1, 7, 32'hFFFF_FFFF, 1, ERR_NONE));
    add_row(8'h02); add_row(8'h02); add_row(8'h00); add_row(8'h08);
    add_row(8'h88); add_row(8'hAB); add_row(8'h00);
    add_row(8'hFF, 0, 1, make_fill(KIND_ERROR, 0, 0, 0, 0, 0, ERR_OVERRUN));
    add_row(8'h02); add_row(8'h02); add_row(8'h00);
    add_row(8'h09, 0, 1, make_fill(KIND_ERROR, 0, 0, 0, 0, 0, ERR_WIDTH));
    add_row(8'h02); add_row(8'h03); add_row(8'h00); add_row(8'h05);
    add_row(8'h7E, 1, 1, make_fill(KIND_ERROR, 0, 0, 0, 0, 0, ERR_TRUNCATED));
    add_row(8'h5A, 0, 1, make_fill(KIND_PIXEL, 0, 0, 0, 0, 1, ERR_NONE), 1, 15'd0);
    foreach (directed_steps[i]) begin
      if (directed_steps[i].set_width) set_line_width(directed_steps[i].width);
      send_byte(directed_steps[i].data_byte, directed_steps[i].eos, directed_steps[i].typed,
                directed_steps[i].fill);
    end

    phase_idx = 0;
    while (bytes_sent < BYTE_TARGET) begin
      if (bytes_sent < BYTE_TARGET / 3) begin
        send_idle_pct = 18;
        recv_idle_pct = 76;
      end else if (bytes_sent < 2 * BYTE_TARGET / 3) begin
        send_idle_pct = 76;
        recv_idle_pct = 18;
      end else begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
      end
      case (phase_idx % 8)
        0: w = 15'd8;
        1: w = 15'd1;
        2: w = 15'($urandom_range(48, 9));
        3: w = 15'd32767;
        4: w = 15'd0;
        5: w = 15'($urandom_range(7, 2));
        6: w = 15'($urandom_range(300, 100));
        default: w = 15'($urandom_range(24, 8));
      endcase
      set_line_width(w);
      lines = $urandom_range(6, 3);
      repeat (lines) begin
        pick = $urandom_range(99);
        if (dec_width == 0) begin
          send_noise(3);
        end else if (pick < 60) begin
          resync();
          if (dec_width >= MIN_NEW_WIDTH) send_new_line(dec_width == 15'd32767);
          else send_old_line(64);
        end else if (pick < 72) begin
          resync();
          send_old_line(64);
        end else if (pick < 84) begin
          resync();
          if (dec_width >= MIN_NEW_WIDTH) send_new_line(1);
          else send_bad_header();
        end else if (pick < 92) begin
          resync();
          send_bad_header();
        end else begin
          send_noise($urandom_range(6, 1));
        end
      end
      if (dec_width != 0 && $urandom_range(2) == 0) send_old_line(2);
      phase_idx++;
    end

    @(negedge clk);
    in_valid <= 1'b0;
    while (pending_fills.size() != 0) @(negedge clk);
    repeat (10) @(negedge clk);
    if (mismatches == 0) $display("Testbench completed without errors");
    else $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule
